[src/assert_macros.svh]
// Assertion macros shared by the gemm tile output stage RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

[src/gtm_pkg.sv]
// Shared types, constants and fp32 helpers for the gemm tile output stage.
// No dependencies.
`timescale 1ns / 1ps
package gtm_pkg;
    localparam int TILE_WIDTH  = 6;
    localparam int TILE_HEIGHT = 8;
    localparam int COL_W = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
    localparam int ROW_W = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [2:0] REG_Y_START     = 3'd0;
    localparam logic [2:0] REG_Y_END       = 3'd1;
    localparam logic [2:0] REG_X_START     = 3'd2;
    localparam logic [2:0] REG_X_END       = 3'd3;
    localparam logic [2:0] REG_ROW_STRIDE  = 3'd4;
    localparam logic [2:0] REG_MERGE_FLAGS = 3'd5;
    localparam logic [2:0] REG_ACT_MODE    = 3'd6;
    localparam logic [2:0] REG_ACT_BOUND   = 3'd7;

    localparam logic [1:0] ACT_RELU    = 2'd1;
    localparam logic [1:0] ACT_BRELU   = 2'd2;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    typedef struct packed {
        logic [15:0] y_start;
        logic [15:0] y_end;
        logic [15:0] x_start;
        logic [15:0] x_end;
        logic [15:0] row_stride;
        logic [1:0]  merge_flags;
        logic [1:0]  act_mode;
        logic [31:0] act_bound;
    } cfg_t;

    typedef struct packed {
        logic [31:0] out_address;
        logic [15:0] bias_column;
        logic        write_enable;
        logic        last_item;
        logic [31:0] tile_value;
        logic [31:0] old_value;
        logic [31:0] bias_value;
    } item_t;

    // fp32 add split in two: align and add, then normalize and round
    typedef struct packed {
        logic        special;
        logic [31:0] special_val;
        logic        sign;
        logic [8:0]  exp;
        logic [27:0] sum;
    } add_pre_t;

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (&x[30:23]) && (|x[22:0]);
    endfunction

    function automatic logic fp_is_inf(input logic [31:0] x);
        return (&x[30:23]) && !(|x[22:0]);
    endfunction

    function automatic add_pre_t fp_add_pre(input logic [31:0] a, input logic [31:0] b);
        add_pre_t    p;
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [4:0]  dd;
        logic [26:0] mx;
        logic [26:0] my;
        logic [26:0] shifted;
        logic        sticky;
        logic [26:0] ys;
        p = '0;
        if (b[30:0] > a[30:0]) begin
            x = b;
            y = a;
        end else begin
            x = a;
            y = b;
        end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        dd = (d > 8'd27) ? 5'd27 : d[4:0];
        mx = {|x[30:23], x[22:0], 3'b000};
        my = {|y[30:23], y[22:0], 3'b000};
        shifted = my >> dd;
        sticky  = |(my & ~(27'h7FF_FFFF << dd));
        ys = {shifted[26:1], shifted[0] | sticky};
        if (x[31] ^ y[31]) begin
            p.sum = {1'b0, mx} - {1'b0, ys};
        end else begin
            p.sum = {1'b0, mx} + {1'b0, ys};
        end
        // exact zero: -0 only when both inputs are negative
        p.sign = (p.sum == 28'd0) ? (x[31] & y[31]) : x[31];
        p.exp  = {1'b0, ex};
        // x86 style NaN propagation: first operand wins
        if (fp_is_nan(a)) begin
            p.special = 1'b1;
            p.special_val = a | FP_QUIET_BIT;
        end else if (fp_is_nan(b)) begin
            p.special = 1'b1;
            p.special_val = b | FP_QUIET_BIT;
        end else if (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31])) begin
            p.special = 1'b1;
            p.special_val = FP_DEFAULT_NAN;
        end else if (fp_is_inf(a)) begin
            p.special = 1'b1;
            p.special_val = a;
        end else if (fp_is_inf(b)) begin
            p.special = 1'b1;
            p.special_val = b;
        end
        return p;
    endfunction

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && v[i]) begin
                n = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] fp_add_post(input add_pre_t p);
        logic [26:0] m;
        logic [8:0]  e;
        logic [4:0]  lz;
        logic [8:0]  lim;
        logic [8:0]  sh;
        logic [7:0]  fld;
        logic        rnd;
        logic [30:0] packed_v;
        if (p.sum[27]) begin
            m = {p.sum[27:2], p.sum[1] | p.sum[0]};
            e = p.exp + 9'd1;
        end else begin
            lz  = lzc27(p.sum[26:0]);
            lim = p.exp - 9'd1;
            sh  = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
            m   = p.sum[26:0] << sh;
            e   = p.exp - sh;
        end
        fld = m[26] ? e[7:0] : 8'd0;
        rnd = m[2] & (m[1] | m[0] | m[3]);
        packed_v = {fld, m[25:3]} + {30'd0, rnd};
        if (p.special) begin
            return p.special_val;
        end else if (e >= 9'd255) begin
            return {p.sign, 8'hFF, 23'd0};
        end else begin
            return {p.sign, packed_v};
        end
    endfunction

    // ordered a < b, false when either is NaN, zeros equal
    function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
        if (fp_is_nan(a) || fp_is_nan(b)) begin
            return 1'b0;
        end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            return 1'b0;
        end else if (a[31] != b[31]) begin
            return a[31];
        end else if (!a[31]) begin
            return a[30:0] < b[30:0];
        end else begin
            return a[30:0] > b[30:0];
        end
    endfunction
endpackage

[src/gtm_front.sv]
// Front end: walks the tile positions, classifies padding and computes addresses.
// Depends on gtm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gtm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  gtm_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [95:0]   in_data,
    output gtm_pkg::item_t q_item,
    output logic          q_push,
    input  logic          q_full
);
    import gtm_pkg::*;

    logic [15:0]      tile_row_base_reg, tile_row_base_next;
    logic [15:0]      tile_col_base_reg, tile_col_base_next;
    logic [ROW_W-1:0] row_in_tile_reg, row_in_tile_next;
    logic [COL_W-1:0] col_in_tile_reg, col_in_tile_next;

    logic [15:0] h;
    logic [15:0] w;
    logic [16:0] r;
    logic [16:0] c;
    logic        pos_valid;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        h = (cfg.y_end > cfg.y_start) ? cfg.y_end - cfg.y_start : 16'd0;
        w = (cfg.x_end > cfg.x_start) ? cfg.x_end - cfg.x_start : 16'd0;
        r = {1'b0, tile_row_base_reg} + 17'(row_in_tile_reg);
        c = {1'b0, tile_col_base_reg} + 17'(col_in_tile_reg);
        pos_valid = (r < {1'b0, h}) && (c < {1'b0, w});
        row = cfg.y_start + r[15:0];
        col = cfg.x_start + c[15:0];

        tile_row_base_next = tile_row_base_reg;
        tile_col_base_next = tile_col_base_reg;
        row_in_tile_next   = row_in_tile_reg;
        col_in_tile_next   = col_in_tile_reg;
        last = 1'b0;
        if (col_in_tile_reg != COL_W'(TILE_WIDTH - 1)) begin
            col_in_tile_next = col_in_tile_reg + 1'b1;
        end else begin
            col_in_tile_next = '0;
            if (row_in_tile_reg != ROW_W'(TILE_HEIGHT - 1)) begin
                row_in_tile_next = row_in_tile_reg + 1'b1;
            end else begin
                row_in_tile_next = '0;
                if ({1'b0, tile_col_base_reg} + 17'(TILE_WIDTH) < {1'b0, w}) begin
                    tile_col_base_next = tile_col_base_reg + 16'(TILE_WIDTH);
                end else begin
                    tile_col_base_next = '0;
                    if ({1'b0, tile_row_base_reg} + 17'(TILE_HEIGHT) < {1'b0, h}) begin
                        tile_row_base_next = tile_row_base_reg + 16'(TILE_HEIGHT);
                    end else begin
                        tile_row_base_next = '0;
                        last = 1'b1;
                    end
                end
            end
        end

        q_item.out_address  = pos_valid ? (32'(row) * 32'(cfg.row_stride) + 32'(col)) : 32'd0;
        q_item.bias_column  = pos_valid ? col : 16'd0;
        q_item.write_enable = pos_valid;
        q_item.last_item    = last;
        q_item.tile_value   = in_data[31:0];
        q_item.old_value    = in_data[63:32];
        q_item.bias_value   = in_data[95:64];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_row_base_reg <= '0;
            tile_col_base_reg <= '0;
            row_in_tile_reg   <= '0;
            col_in_tile_reg   <= '0;
        end
        else if (q_push)
        begin
            tile_row_base_reg <= tile_row_base_next;
            tile_col_base_reg <= tile_col_base_next;
            row_in_tile_reg   <= row_in_tile_next;
            col_in_tile_reg   <= col_in_tile_next;
        end
    end

    `ASSERT_NEVER(a_col_range, clk, rst_n, col_in_tile_reg > COL_W'(TILE_WIDTH - 1), "col out of tile")
    `ASSERT_CLK(a_last_wraps, clk, rst_n, q_push && last |=> (row_in_tile_reg == '0) && (tile_row_base_reg == '0), "last without wrap")
endmodule

[src/gtm_queue.sv]
// Short queue of classified items between front and back end.
// Depends on gtm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gtm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gtm_pkg::item_t push_item,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output gtm_pkg::item_t head_item
);
    import gtm_pkg::*;

    item_t             slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `ASSERT_NEVER(a_overflow, clk, rst_n, push && full, "push into full queue")
    `ASSERT_NEVER(a_underflow, clk, rst_n, pop && !not_empty, "pop from empty queue")
endmodule

[src/gtm_back.sv]
// Back end: two fp32 adds (append, bias) and activation, five stages, elastic.
// Depends on gtm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gtm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  gtm_pkg::cfg_t  cfg,
    input  logic           q_not_empty,
    input  gtm_pkg::item_t q_head,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [79:0]    out_data,
    output logic           out_we,
    output logic           out_last
);
    import gtm_pkg::*;

    typedef struct packed {
        logic [31:0] out_address;
        logic [15:0] bias_column;
        logic        write_enable;
        logic        last_item;
    } meta_t;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic        rdy1, rdy2, rdy3, rdy4, rdy5;
    meta_t       m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    add_pre_t    p1_reg, p3_reg;
    logic [31:0] a1_reg, a2_reg, a3_reg, a4_reg, val5_reg;
    logic [31:0] b1_reg, b2_reg;
    logic [31:0] val4;
    logic [31:0] act_val;
    meta_t       m0;

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign q_pop = q_not_empty && rdy1;

    assign m0.out_address  = q_head.out_address;
    assign m0.bias_column  = q_head.bias_column;
    assign m0.write_enable = q_head.write_enable;
    assign m0.last_item    = q_head.last_item;

    // a*_reg carries the value before each add so a disabled add passes it untouched
    assign val4 = cfg.merge_flags[1] ? fp_add_post(p3_reg) : a3_reg;

    // stage 4 is a plain register of the second add; the activation reads it
    always_comb
    begin
        act_val = a4_reg;
        if (cfg.act_mode == ACT_BRELU && fp_lt(cfg.act_bound, act_val)) begin
            act_val = cfg.act_bound;
        end
        if ((cfg.act_mode == ACT_RELU || cfg.act_mode == ACT_BRELU)
            && fp_lt(act_val, 32'd0)) begin
            act_val = 32'd0;
        end
        if (!m4_reg.write_enable) begin
            act_val = 32'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            m1_reg <= m0;
            p1_reg <= fp_add_pre(q_head.tile_value, q_head.old_value);
            a1_reg <= q_head.tile_value;
            b1_reg <= q_head.bias_value;
        end
        if (v1_reg && rdy2)
        begin
            m2_reg <= m1_reg;
            a2_reg <= cfg.merge_flags[0] ? fp_add_post(p1_reg) : a1_reg;
            b2_reg <= b1_reg;
        end
        if (v2_reg && rdy3)
        begin
            m3_reg <= m2_reg;
            p3_reg <= fp_add_pre(a2_reg, b2_reg);
            a3_reg <= a2_reg;
        end
        if (v3_reg && rdy4)
        begin
            m4_reg <= m3_reg;
            a4_reg <= val4;
        end
        if (v4_reg && rdy5)
        begin
            m5_reg   <= m4_reg;
            val5_reg <= act_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= q_pop;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = {val5_reg, m5_reg.bias_column, m5_reg.out_address};
    assign out_we    = m5_reg.write_enable;
    assign out_last  = m5_reg.last_item;

    `ASSERT_CLK(a_pad_zero, clk, rst_n, out_valid && !out_we |-> (out_data == 80'd0), "padding not zero")
    `ASSERT_CLK(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result lost under stall")
endmodule

[src/gemm_tile_merge_bias_activation_top.sv]
// Top level of the gemm tile output stage: configuration registers and wiring.
// Depends on gtm_pkg, gtm_front, gtm_queue, gtm_back.
`timescale 1ns / 1ps
// Takes one accumulator tile entry per cycle while the queue is not full and
// returns one result per entry, in order. An entry passes through the front
// end into a queue slot, then through five back-end stages to the master side
// (two per fp32 add, one for activation). The four-entry queue lets the front
// end keep taking entries while the output is stalled, until it is full.
// Write configuration only while no entry is in flight.
module gemm_tile_merge_bias_activation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // tile_value, old_value, bias_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // out_address, bias_column, out_value
    output logic        m_axis_tuser,   // write_enable
    output logic        m_axis_tlast    // last_item
);
    import gtm_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item;
    item_t head_item;
    logic  push, full, not_empty, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_Y_START:     cfg_reg.y_start     <= cfg_data[15:0];
                REG_Y_END:       cfg_reg.y_end       <= cfg_data[15:0];
                REG_X_START:     cfg_reg.x_start     <= cfg_data[15:0];
                REG_X_END:       cfg_reg.x_end       <= cfg_data[15:0];
                REG_ROW_STRIDE:  cfg_reg.row_stride  <= cfg_data[15:0];
                REG_MERGE_FLAGS: cfg_reg.merge_flags <= cfg_data[1:0];
                REG_ACT_MODE:    cfg_reg.act_mode    <= cfg_data[1:0];
                REG_ACT_BOUND:   cfg_reg.act_bound   <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    gtm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .q_item    (push_item),
        .q_push    (push),
        .q_full    (full)
    );

    gtm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .not_empty (not_empty),
        .pop       (pop),
        .head_item (head_item)
    );

    gtm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (not_empty),
        .q_head      (head_item),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_we      (m_axis_tuser),
        .out_last    (m_axis_tlast)
    );
endmodule

[tb/sv/testbench.sv]
// Self-checking bench for gemm_tile_merge_bias_activation_top: walks tile streams
// through several region and merge/activation settings and checks every result.
// Depends on gtm_pkg and the RTL of the block.
`timescale 1ns / 1ps
module testbench;
    import gtm_pkg::*;

    typedef struct {
        logic [31:0] addr;
        logic [15:0] col;
        logic        wr;
        logic [31:0] val;
        logic        last;
    } tile_result_t;

    typedef struct {
        logic [31:0] tile;
        logic [31:0] old;
        logic [31:0] bias;
        logic        known;   // out_value typed in below
        logic [31:0] val;
    } drive_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;    // tile_value, old_value, bias_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // out_address, bias_column, out_value
    logic        m_axis_tuser;    // write_enable
    logic        m_axis_tlast;    // last_item

    gemm_tile_merge_bias_activation_top uut (.*);

    // predictor copy of configuration and position
    logic [15:0] y0, y1, x0, x1, stride;
    logic [1:0]  mflags, amode;
    logic [31:0] bound;
    int unsigned trow, tcol, rit, cit;

    tile_result_t pending_results[$];
    int  n_fail, n_sent, n_checked, n_last, n_pad;
    bit  idle_en;
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end
    always #5 clk = ~clk;

    function automatic logic is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 0);
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 0);
    endfunction

    // fp32 a < b, unordered gives false
    function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b))
            return 1'b0;
        if (a[30:0] == 0 && b[30:0] == 0)
            return 1'b0;
        if (a[31] != b[31])
            return a[31];
        return a[31] ? (a[30:0] > b[30:0]) : (a[30:0] < b[30:0]);
    endfunction

    // fp32 add, round to nearest even; NaN of the first operand wins
    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi, lo;
        logic [63:0] wh, wl, r, mant, pk;
        int          eh, el, d, p, e, s, eff;
        logic        g, st;
        if (is_nan(a))
            return a | FP_QUIET_BIT;
        if (is_nan(b))
            return b | FP_QUIET_BIT;
        if (is_inf(a) && is_inf(b) && a[31] != b[31])
            return FP_DEFAULT_NAN;
        if (is_inf(a))
            return a;
        if (is_inf(b))
            return b;
        if (b[30:0] > a[30:0])
        begin
            hi = b;
            lo = a;
        end
        else
        begin
            hi = a;
            lo = b;
        end
        eh = (hi[30:23] == 0) ? 1 : hi[30:23];
        el = (lo[30:23] == 0) ? 1 : lo[30:23];
        wh = {40'd0, hi[30:23] != 0, hi[22:0]} << 26;
        wl = {40'd0, lo[30:23] != 0, lo[22:0]} << 26;
        d = eh - el;
        if (d >= 50)
        begin
            st = |wl;
            wl = 0;
        end
        else
        begin
            st = |(wl & ((64'd1 << d) - 1));
            wl = wl >> d;
        end
        wl[0] = wl[0] | st;
        r = (hi[31] == lo[31]) ? wh + wl : wh - wl;
        if (r == 0)
            return {hi[31] & lo[31], 31'd0};
        p = 0;
        for (int i = 0; i < 64; i++)
            if (r[i])
                p = i;
        e = eh + p - 49;
        s = p - 23;
        if (e < 1)
            s = s + 1 - e;
        if (s <= 0)
        begin
            mant = r << (-s);
            g = 1'b0;
            st = 1'b0;
        end
        else
        begin
            mant = r >> s;
            g = r[s-1];
            st = |(r & ((64'd1 << (s - 1)) - 1));
        end
        if (g && (st || mant[0]))
            mant = mant + 1;
        eff = (e < 1) ? 1 : e;
        pk = (64'(eff - 1) << 23) + mant;
        if (pk >= 64'h7F80_0000)
            return {hi[31], 8'hFF, 23'd0};
        return {hi[31], pk[30:0]};
    endfunction

    function automatic void set_reg(input logic [2:0] idx, input logic [31:0] v);
        case (idx)
            REG_Y_START:     y0 = v[15:0];
            REG_Y_END:       y1 = v[15:0];
            REG_X_START:     x0 = v[15:0];
            REG_X_END:       x1 = v[15:0];
            REG_ROW_STRIDE:  stride = v[15:0];
            REG_MERGE_FLAGS: mflags = v[1:0];
            REG_ACT_MODE:    amode = v[1:0];
            REG_ACT_BOUND:   bound = v;
            default: ;
        endcase
    endfunction

    // result of one tile entry; advances the tile walk
    function automatic tile_result_t merge_entry(input logic [95:0] d);
        tile_result_t res;
        int unsigned  h, w, r, c;
        logic [31:0]  v, row, col;
        h = (y1 > y0) ? y1 - y0 : 0;
        w = (x1 > x0) ? x1 - x0 : 0;
        r = trow + rit;
        c = tcol + cit;
        res = '{default: '0};
        if (r < h && c < w)
        begin
            row = y0 + r;
            col = x0 + c;
            v = d[31:0];
            if (mflags[0])
                v = fadd(v, d[63:32]);
            if (mflags[1])
                v = fadd(v, d[95:64]);
            if (amode == ACT_RELU)
            begin
                if (flt(v, 32'd0))
                    v = 32'd0;
            end
            else if (amode == ACT_BRELU)
            begin
                if (flt(bound, v))
                    v = bound;
                if (flt(v, 32'd0))
                    v = 32'd0;
            end
            res.addr = row * {16'd0, stride} + col;
            res.col = col[15:0];
            res.wr = 1'b1;
            res.val = v;
        end
        cit++;
        if (cit >= TILE_WIDTH)
        begin
            cit = 0;
            rit++;
            if (rit >= TILE_HEIGHT)
            begin
                rit = 0;
                if (tcol + TILE_WIDTH < w)
                    tcol += TILE_WIDTH;
                else
                begin
                    tcol = 0;
                    if (trow + TILE_HEIGHT < h)
                        trow += TILE_HEIGHT;
                    else
                    begin
                        trow = 0;
                        res.last = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_fp();
        logic [31:0] specials[12] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
            32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFF81_2345, 32'h0000_0001,
            32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000};
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return specials[$urandom_range(0, 11)];
            2: return {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom)};
            3: return {$urandom_range(0, 1) == 1, 8'd254, 23'($urandom)};
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(123, 131)),
                             23'($urandom)};
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        set_reg(idx, v);
    endtask

    task automatic write_all(input logic [15:0] ys, input logic [15:0] ye,
                             input logic [15:0] xs, input logic [15:0] xe,
                             input logic [15:0] st, input logic [1:0] mf,
                             input logic [1:0] am, input logic [31:0] bd);
        write_reg(REG_Y_START, ys);
        write_reg(REG_Y_END, ye);
        write_reg(REG_X_START, xs);
        write_reg(REG_X_END, xe);
        write_reg(REG_ROW_STRIDE, st);
        write_reg(REG_MERGE_FLAGS, mf);
        write_reg(REG_ACT_MODE, am);
        write_reg(REG_ACT_BOUND, bd);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        wait (pending_results.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_entry(input logic [95:0] d, output tile_result_t res);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = merge_entry(d);
        pending_results.push_back(res);
        n_sent++;
    endtask

    // output side: random stall bursts
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        tile_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                n_fail++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (exp_r.last)
                    n_last++;
                if (!exp_r.wr)
                    n_pad++;
                if (m_axis_tdata[31:0] !== exp_r.addr)
                begin
                    $error("out_address exp %h got %h", exp_r.addr, m_axis_tdata[31:0]);
                    n_fail++;
                end
                if (m_axis_tdata[47:32] !== exp_r.col)
                begin
                    $error("bias_column exp %h got %h", exp_r.col, m_axis_tdata[47:32]);
                    n_fail++;
                end
                if (m_axis_tuser !== exp_r.wr)
                begin
                    $error("write_enable exp %b got %b", exp_r.wr, m_axis_tuser);
                    n_fail++;
                end
                if (m_axis_tdata[79:48] !== exp_r.val)
                begin
                    $error("out_value exp %h got %h", exp_r.val, m_axis_tdata[79:48]);
                    n_fail++;
                end
                if (m_axis_tlast !== exp_r.last)
                begin
                    $error("last_item exp %b got %b", exp_r.last, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 2000)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        drive_row_t   rows[$];
        tile_result_t res;
        logic [15:0]  ys, xs;
        int           n_items;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        idle_en = 1'b1;
        quiet_cycles = 0;
        n_fail = 0;
        n_sent = 0;
        n_checked = 0;
        n_last = 0;
        n_pad = 0;
        y0 = 0; y1 = 0; x0 = 0; x1 = 0; stride = 0;
        mflags = 0; amode = 0; bound = 0;
        trow = 0; tcol = 0; rit = 0; cit = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: empty region, one tile of padding
        for (int i = 0; i < TILE_WIDTH * TILE_HEIGHT; i++)
        begin
            send_entry({$urandom, $urandom, $urandom}, res);
            if (res.wr || res.val != 0)
            begin
                $error("predictor: padding entry not zero");
                n_fail++;
            end
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // full single tile, append + bias, bounded ReLU at 6.0
        write_all(16'd0, 16'd8, 16'd0, 16'd6, 16'd6, 2'd3, ACT_BRELU, 32'h40C0_0000);
        rows = '{
            '{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 1'b1, 32'h40C0_0000},
            '{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h4040_0000},
            '{32'hC000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{32'h4120_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h40C0_0000},
            '{32'h7FC0_0001, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 32'h7FC0_0001},
            '{32'h7F80_0001, 32'h3F80_0000, 32'h0000_0000, 1'b1, 32'h7FC0_0001},
            '{32'h3F80_0000, 32'hFF81_0000, 32'h0000_0000, 1'b1, 32'hFFC1_0000},
            '{32'h7F80_0000, 32'hFF80_0000, 32'h0000_0000, 1'b1, FP_DEFAULT_NAN},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
            '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 1'b1, 32'h40C0_0000},
            '{32'h0000_0001, 32'h8000_0001, 32'h0000_0000, 1'b1, 32'h0000_0000},
            '{32'h007F_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0},
            '{32'h3F80_0000, 32'h3380_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{32'h3F80_0001, 32'hBF80_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
            '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
            '{32'h4B80_0001, 32'h3F00_0000, 32'h0000_0000, 1'b0, 32'h0},
            '{32'hBF80_0000, 32'h3F80_0000, 32'h8000_0000, 1'b1, 32'h0000_0000}
        };
        foreach (rows[i])
        begin
            send_entry({rows[i].bias, rows[i].old, rows[i].tile}, res);
            if (rows[i].known && res.val !== rows[i].val)
            begin
                $error("out_value exp %h got %h", rows[i].val, res.val);
                n_fail++;
            end
        end
        // rest of the tile, then one more to see the wrap
        for (int i = rows.size(); i < TILE_WIDTH * TILE_HEIGHT + 1; i++)
            send_entry({rand_fp(), rand_fp(), rand_fp()}, res);
        s_axis_tvalid <= 1'b0;
        drain();

        for (int ph = 0; ph < 14; ph++)
        begin
            n_items = 120;
            case (ph)
                0: write_all(16'd65530, 16'd65535, 16'd65530, 16'hFFFF, 16'hFFFF,
                             2'd3, ACT_RELU, 32'h7FC0_0000);
                1: write_all(16'd5, 16'd3, 16'd7, 16'd20, 16'd1, 2'd0, 2'd3, 32'h0);
                2: write_all(16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 2'd1, 2'd0, 32'hFFFF_FFFF);
                3: write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3,
                             2'd2, ACT_BRELU, 32'h8000_0000);
                default:
                begin
                    ys = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
                    xs = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
                    write_all(ys, ys + 16'($urandom_range(0, 20)), xs,
                              xs + 16'($urandom_range(0, 20)), 16'($urandom),
                              2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              $urandom_range(0, 1) ? rand_fp() : 32'h4000_0000);
                end
            endcase
            if (ph == 13)
                idle_en = 1'b0;
            for (int i = 0; i < n_items; i++)
                send_entry({rand_fp(), rand_fp(), rand_fp()}, res);
            s_axis_tvalid <= 1'b0;
            drain();
        end

        $display("sent %0d tile entries, checked %0d results (%0d padding, %0d region ends)",
                 n_sent, n_checked, n_pad, n_last);
        $display("over 16 register settings incl. empty and top-of-range regions");
        if (n_fail == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
